>>> rtl/lpf_pkg.sv
package lpf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIFF_W     = 33;
    localparam int SQ_W       = 66;
    localparam int CX_W       = 36;
    localparam int TH_W       = 34;

    localparam longint KINF_Q30  = 64'd652032875;
    localparam longint KTAIL_Q30 = 64'd434688583;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_POSE   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REG_ENABLE    = 3'd0,
        REG_LOOKAHEAD = 3'd1,
        REG_MAX_H     = 3'd2,
        REG_MAX_V     = 3'd3,
        REG_YAW_RATE  = 3'd4,
        REG_GAIN_H    = 3'd5,
        REG_GAIN_V    = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
    } search_res_t;

    // arctan(2^-k), 2^31 = pi
    function automatic logic [31:0] atan_at(input logic [4:0] k);
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/lpf_in_if.sv
interface lpf_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] heading;

    modport source (output valid, output command, output pos_x, output pos_y,
                    output pos_z, output heading, input ready);
    modport sink (input valid, input command, input pos_x, input pos_y,
                  input pos_z, input heading, output ready);
endinterface

>>> rtl/lpf_out_if.sv
interface lpf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vel_forward;
    logic signed [31:0] vel_left;
    logic signed [31:0] vel_up;
    logic signed [31:0] yaw_rate;

    modport source (output valid, output vel_forward, output vel_left, output vel_up,
                    output yaw_rate, input ready);
    modport sink (input valid, input vel_forward, input vel_left, input vel_up,
                  input yaw_rate, output ready);
endinterface

>>> rtl/lpf_path_mem.sv
module lpf_path_mem #(
    parameter int DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  lpf_pkg::point_t            wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output lpf_pkg::point_t            rdata
);
    import lpf_pkg::*;

    point_t mem [DEPTH];
    point_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lpf_search.sv
module lpf_search #(
    parameter int MAX_POINTS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(MAX_POINTS+1)-1:0]     path_len,
    input  logic signed [31:0]                  pose_x,
    input  logic signed [31:0]                  pose_y,
    input  logic signed [31:0]                  pose_z,
    input  logic [61:0]                         reach_sq,
    output logic                                rd_en,
    output logic [$clog2(MAX_POINTS)-1:0]       rd_addr,
    input  lpf_pkg::point_t                     rd_data,
    output lpf_pkg::search_res_t                res
);
    import lpf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);

    typedef enum logic [2:0] {
        SR_IDLE = 3'b001,
        SR_NEAR = 3'b010,
        SR_LOOK = 3'b100
    } sr_state_t;

    sr_state_t state_reg;
    logic [ADDR_W-1:0] issue_reg, idx1_reg, idx2_reg, idx3_reg, near_reg;
    logic issuing_reg, v1_reg, v2_reg, v3_reg, done_reg;
    logic signed [DIFF_W-1:0] d2x_reg, d2y_reg, d2z_reg;
    logic signed [DIFF_W-1:0] d3x_reg, d3y_reg, d3z_reg;
    logic signed [DIFF_W-1:0] lx_reg, ly_reg, lz_reg;
    logic [DIFF_W-1:0] m2x_reg, m2y_reg, m2z_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg, best_reg;

    logic [ADDR_W-1:0] last_idx, near_now;
    logic signed [DIFF_W-1:0] d1x, d1y, d1z;
    logic [SQ_W-1:0] sum3;
    logic near_end, look_end, take_near;

    function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    assign last_idx = ADDR_W'(path_len - 1'b1);

    assign d1x = $signed({rd_data.x[31], rd_data.x}) - $signed({pose_x[31], pose_x});
    assign d1y = $signed({rd_data.y[31], rd_data.y}) - $signed({pose_y[31], pose_y});
    assign d1z = $signed({rd_data.z[31], rd_data.z}) - $signed({pose_z[31], pose_z});

    assign sum3      = sqx_reg + sqy_reg + sqz_reg;
    assign take_near = (idx3_reg == '0) || (sum3 < best_reg);
    assign near_now  = take_near ? idx3_reg : near_reg;
    assign near_end  = v3_reg && (state_reg == SR_NEAR) && (idx3_reg == last_idx);
    assign look_end  = v3_reg && (state_reg == SR_LOOK) &&
                       ((sum3 >= SQ_W'(reach_sq)) || (idx3_reg == last_idx));

    assign rd_en   = issuing_reg;
    assign rd_addr = issue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SR_IDLE;
            issuing_reg <= 1'b0;
            issue_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= look_end;
            v1_reg   <= issuing_reg && !look_end;
            v2_reg   <= v1_reg && !look_end;
            v3_reg   <= v2_reg && !look_end;
            if (start)
            begin
                state_reg   <= SR_NEAR;
                issue_reg   <= '0;
                issuing_reg <= 1'b1;
            end
            else if (near_end)
            begin
                // second pass walks forward from the nearest point
                state_reg   <= SR_LOOK;
                issue_reg   <= near_now;
                issuing_reg <= 1'b1;
            end
            else if (look_end)
            begin
                state_reg   <= SR_IDLE;
                issuing_reg <= 1'b0;
            end
            else if (issuing_reg)
            begin
                if (issue_reg == last_idx)
                    issuing_reg <= 1'b0;
                else
                    issue_reg <= issue_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= issue_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        d2x_reg  <= d1x;
        d2y_reg  <= d1y;
        d2z_reg  <= d1z;
        m2x_reg  <= mag33(d1x);
        m2y_reg  <= mag33(d1y);
        m2z_reg  <= mag33(d1z);
        d3x_reg  <= d2x_reg;
        d3y_reg  <= d2y_reg;
        d3z_reg  <= d2z_reg;
        sqx_reg  <= SQ_W'(m2x_reg) * SQ_W'(m2x_reg);
        sqy_reg  <= SQ_W'(m2y_reg) * SQ_W'(m2y_reg);
        sqz_reg  <= SQ_W'(m2z_reg) * SQ_W'(m2z_reg);
        if (v3_reg && (state_reg == SR_NEAR) && take_near)
        begin
            best_reg <= sum3;
            near_reg <= idx3_reg;
        end
        if (look_end)
        begin
            lx_reg <= d3x_reg;
            ly_reg <= d3y_reg;
            lz_reg <= d3z_reg;
        end
    end

    assign res.done = done_reg;
    assign res.dx   = lx_reg;
    assign res.dy   = ly_reg;
    assign res.dz   = lz_reg;

endmodule

>>> rtl/lpf_scale.sv
module lpf_scale (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] ax,
    input  logic [30:0] ay,
    input  logic [30:0] limit,
    input  logic [62:0] sum_sq,
    output logic        done,
    output logic [30:0] qx,
    output logic [30:0] qy
);
    import lpf_pkg::*;

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_SQRT = 4'b0010,
        SC_MUL  = 4'b0100,
        SC_DIV  = 4'b1000
    } sc_state_t;

    sc_state_t state_reg;
    logic [63:0] rad_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] drem_reg;
    logic [61:0] num_reg;
    logic [5:0]  cnt_reg;
    logic [30:0] ax_reg, ay_reg, lim_reg, qx_reg, qy_reg;
    logic        sel_y_reg, done_reg;

    logic [34:0] rem_sh, trial;
    logic        sq_ge, dv_ge;
    logic [32:0] dsh;
    logic [61:0] num_next;
    logic [30:0] quot;

    assign rem_sh = {rem_reg[32:0], rad_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign sq_ge  = rem_sh >= trial;

    assign dsh      = {drem_reg, num_reg[61]};
    assign dv_ge    = dsh >= {1'b0, root_reg};
    assign num_next = {num_reg[60:0], dv_ge};
    // zero speed gives zero components
    assign quot     = (root_reg == '0) ? '0 : num_next[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SC_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            sel_y_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                SC_IDLE:
                    if (start)
                    begin
                        state_reg <= SC_SQRT;
                        cnt_reg   <= '0;
                        sel_y_reg <= 1'b0;
                    end
                SC_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd31)
                        state_reg <= SC_MUL;
                end
                SC_MUL:
                begin
                    cnt_reg   <= '0;
                    state_reg <= SC_DIV;
                end
                SC_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 6'd61)
                    begin
                        if (sel_y_reg)
                        begin
                            state_reg <= SC_IDLE;
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            sel_y_reg <= 1'b1;
                            state_reg <= SC_MUL;
                        end
                    end
                end
                default: state_reg <= SC_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == SC_IDLE && start)
        begin
            rad_reg  <= {1'b0, sum_sq};
            rem_reg  <= '0;
            root_reg <= '0;
            ax_reg   <= ax;
            ay_reg   <= ay;
            lim_reg  <= limit;
        end
        if (state_reg == SC_SQRT)
        begin
            rem_reg  <= sq_ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[30:0], sq_ge};
            rad_reg  <= {rad_reg[61:0], 2'b00};
        end
        if (state_reg == SC_MUL)
        begin
            num_reg  <= 62'(sel_y_reg ? ay_reg : ax_reg) * 62'(lim_reg);
            drem_reg <= '0;
        end
        if (state_reg == SC_DIV)
        begin
            drem_reg <= dv_ge ? 32'(dsh - {1'b0, root_reg}) : dsh[31:0];
            num_reg  <= num_next;
            if (cnt_reg == 6'd61)
            begin
                if (sel_y_reg)
                    qy_reg <= quot;
                else
                    qx_reg <= quot;
            end
        end
    end

    assign done = done_reg;
    assign qx   = qx_reg;
    assign qy   = qy_reg;

endmodule

>>> rtl/lpf_cordic.sv
module lpf_cordic #(
    parameter int STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] vx,
    input  logic signed [31:0] vy,
    input  logic signed [15:0] heading,
    output logic               done,
    output logic signed [31:0] fwd,
    output logic signed [31:0] left
);
    import lpf_pkg::*;

    localparam longint KQ = KINF_Q30 + (KTAIL_Q30 >> (2 * STEPS));
    localparam logic signed [31:0] KQ_S = 32'(KQ);
    localparam logic signed [TH_W-1:0] HALF_PI = 34'sh0_4000_0000;
    localparam logic signed [TH_W-1:0] PI_ANG  = 34'sh0_8000_0000;
    localparam logic signed [67:0] SAT_HI = 68'sh0_0000_0000_7FFF_FFFF;
    localparam logic signed [67:0] SAT_LO = -68'sh0_0000_0000_8000_0000;

    typedef enum logic [3:0] {
        CO_IDLE = 4'b0001,
        CO_ROT  = 4'b0010,
        CO_MUL  = 4'b0100,
        CO_SAT  = 4'b1000
    } co_state_t;

    co_state_t state_reg;
    logic [4:0] k_reg;
    logic signed [CX_W-1:0] x_reg, y_reg;
    logic signed [TH_W-1:0] th_reg;
    logic signed [67:0] px_reg, py_reg;
    logic signed [31:0] fwd_reg, left_reg;
    logic done_reg;

    logic signed [TH_W-1:0] th0, at;
    logic signed [CX_W-1:0] x0, y0, dxs, dys;
    logic signed [67:0] sx, sy;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > SAT_HI)
            return 32'sh7FFF_FFFF;
        if (v < SAT_LO)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    assign th0 = -$signed({{2{heading[15]}}, heading, 16'h0000});
    assign x0  = CX_W'(vx);
    assign y0  = CX_W'(vy);
    assign dxs = y_reg >>> k_reg;
    assign dys = x_reg >>> k_reg;
    assign at  = $signed({2'b00, atan_at(k_reg)});
    assign sx  = px_reg >>> 30;
    assign sy  = py_reg >>> 30;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CO_IDLE;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                CO_IDLE:
                    if (start)
                    begin
                        state_reg <= CO_ROT;
                        k_reg     <= '0;
                    end
                CO_ROT:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 5'(STEPS - 1))
                        state_reg <= CO_MUL;
                end
                CO_MUL: state_reg <= CO_SAT;
                CO_SAT:
                begin
                    state_reg <= CO_IDLE;
                    done_reg  <= 1'b1;
                end
                default: state_reg <= CO_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CO_IDLE && start)
        begin
            // fold the angle into +-pi/2 with a half-turn
            if (th0 > HALF_PI)
            begin
                x_reg  <= -x0;
                y_reg  <= -y0;
                th_reg <= th0 - PI_ANG;
            end
            else if (th0 < -HALF_PI)
            begin
                x_reg  <= -x0;
                y_reg  <= -y0;
                th_reg <= th0 + PI_ANG;
            end
            else
            begin
                x_reg  <= x0;
                y_reg  <= y0;
                th_reg <= th0;
            end
        end
        if (state_reg == CO_ROT)
        begin
            if (!th_reg[TH_W-1])
            begin
                x_reg  <= x_reg - dxs;
                y_reg  <= y_reg + dys;
                th_reg <= th_reg - at;
            end
            else
            begin
                x_reg  <= x_reg + dxs;
                y_reg  <= y_reg - dys;
                th_reg <= th_reg + at;
            end
        end
        if (state_reg == CO_MUL)
        begin
            px_reg <= 68'(x_reg) * 68'(KQ_S);
            py_reg <= 68'(y_reg) * 68'(KQ_S);
        end
        if (state_reg == CO_SAT)
        begin
            fwd_reg  <= sat32(sx);
            left_reg <= sat32(sy);
        end
    end

    assign done = done_reg;
    assign fwd  = fwd_reg;
    assign left = left_reg;

endmodule

>>> rtl/lookahead_path_follower_core.sv
// Clear, append and pose words do not hold off the next word; no word is accepted while
// a tick runs. An enabled tick with pose and path raises its velocity word after the two
// path passes (one point a cycle through the memory read port), gain and limit check, the
// speed limiter when it engages, the rotation, and output with any output stall; without
// pose or path it goes straight to output with a zero word.
// Reset restores the register defaults, empties the path and drops the pose; the path
// memory itself is not cleared.
module lookahead_path_follower_core #(
    parameter int MAX_POINTS   = 256,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lpf_pkg::CFG_DATA_W-1:0]   cfg_data,
    lpf_in_if.sink                           cmd_ch,
    lpf_out_if.source                        vel_ch
);
    import lpf_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int LEN_W  = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SEARCH = 9'b000000010,
        ST_GAIN   = 9'b000000100,
        ST_SQ     = 9'b000001000,
        ST_CMP    = 9'b000010000,
        ST_SCALE  = 9'b000100000,
        ST_ROT    = 9'b001000000,
        ST_CORDIC = 9'b010000000,
        ST_OUT    = 9'b100000000
    } st_t;

    st_t state_reg, state_next;

    logic               enable_reg;
    logic [30:0]        la_reg, mh_reg, mv_reg;
    logic signed [31:0] yaw_reg;
    logic [15:0]        gh_reg, gv_reg;
    logic [LEN_W-1:0]   len_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg, pose_z_reg;
    logic signed [15:0] heading_reg;
    logic               pose_valid_reg;
    logic [61:0]        l2_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [40:0]        ax_reg, ay_reg;
    logic               sx_reg, sy_reg;
    logic signed [41:0] vz_reg;
    logic [30:0]        axs_reg, ays_reg;
    logic               big_reg;
    logic [61:0]        sqx_reg, sqy_reg, mh2_reg;
    logic signed [31:0] vx_reg, vy_reg, vzc_reg;
    logic signed [31:0] res_f_reg, res_l_reg, res_u_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_f_reg, out_l_reg, out_u_reg, out_y_reg;

    cmd_t        cmd;
    logic        in_acc, tick_go, tick_zero, out_free, over;
    logic        mem_we, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    point_t      wr_pt, rd_pt;
    search_res_t srch_res;
    logic        scl_start, scl_done, rot_done;
    logic [30:0] qx, qy;
    logic signed [31:0] rot_f, rot_l;
    logic [32:0] mx, my, mz;
    logic [48:0] gx, gy, gz;
    logic [9:0]  hi_bits;
    logic [3:0]  sh;
    logic [40:0] ax_sh, ay_sh;
    logic [62:0] hsum;
    logic signed [41:0] mv_s;
    logic signed [31:0] vz_clamp;

    assign cmd       = cmd_t'(cmd_ch.command);
    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign in_acc    = cmd_ch.valid && cmd_ch.ready;
    assign tick_go   = in_acc && (cmd == CMD_TICK) && enable_reg && pose_valid_reg &&
                       (len_reg != '0);
    assign tick_zero = in_acc && (cmd == CMD_TICK) && enable_reg &&
                       !(pose_valid_reg && (len_reg != '0));
    assign out_free  = !out_valid_reg || vel_ch.ready;

    assign mem_we = in_acc && (cmd == CMD_APPEND) && (len_reg < LEN_W'(MAX_POINTS));
    assign wr_pt  = '{x: cmd_ch.pos_x, y: cmd_ch.pos_y, z: cmd_ch.pos_z};

    lpf_path_mem #(.DEPTH(MAX_POINTS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (len_reg[ADDR_W-1:0]),
        .wdata (wr_pt),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_pt)
    );

    lpf_search #(.MAX_POINTS(MAX_POINTS)) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (tick_go),
        .path_len (len_reg),
        .pose_x   (pose_x_reg),
        .pose_y   (pose_y_reg),
        .pose_z   (pose_z_reg),
        .reach_sq (l2_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_pt),
        .res      (srch_res)
    );

    // gain products, truncated toward zero
    assign mx = dx_reg[DIFF_W-1] ? 33'(-dx_reg) : 33'(dx_reg);
    assign my = dy_reg[DIFF_W-1] ? 33'(-dy_reg) : 33'(dy_reg);
    assign mz = dz_reg[DIFF_W-1] ? 33'(-dz_reg) : 33'(dz_reg);
    assign gx = 49'(mx) * 49'(gh_reg);
    assign gy = 49'(my) * 49'(gh_reg);
    assign gz = 49'(mz) * 49'(gv_reg);

    // shift both components below 2^31 before squaring
    assign hi_bits = ax_reg[40:31] | ay_reg[40:31];
    always_comb
    begin
        sh = '0;
        for (int b = 0; b < 10; b++)
            if (hi_bits[b])
                sh = 4'(b + 1);
    end
    assign ax_sh = ax_reg >> sh;
    assign ay_sh = ay_reg >> sh;

    assign hsum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign over = big_reg || (hsum > {1'b0, mh2_reg});
    assign scl_start = (state_reg == ST_CMP) && over;

    assign mv_s = $signed({11'b0, mv_reg});
    assign vz_clamp = (vz_reg > mv_s) ? 32'(mv_s) :
                      (vz_reg < -mv_s) ? 32'(-mv_s) : 32'(vz_reg);

    lpf_scale u_scale (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (scl_start),
        .ax     (axs_reg),
        .ay     (ays_reg),
        .limit  (mh_reg),
        .sum_sq (hsum),
        .done   (scl_done),
        .qx     (qx),
        .qy     (qy)
    );

    lpf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (state_reg == ST_ROT),
        .vx      (vx_reg),
        .vy      (vy_reg),
        .heading (heading_reg),
        .done    (rot_done),
        .fwd     (rot_f),
        .left    (rot_l)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (tick_go)
                    state_next = ST_SEARCH;
                else if (tick_zero)
                    state_next = ST_OUT;
            ST_SEARCH:
                if (srch_res.done)
                    state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_SQ;
            ST_SQ:     state_next = ST_CMP;
            ST_CMP:    state_next = over ? ST_SCALE : ST_ROT;
            ST_SCALE:
                if (scl_done)
                    state_next = ST_ROT;
            ST_ROT:    state_next = ST_CORDIC;
            ST_CORDIC:
                if (rot_done)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_free)
                    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            enable_reg     <= 1'b1;
            la_reg         <= 31'd65536;
            mh_reg         <= 31'd65536;
            mv_reg         <= 31'd32768;
            yaw_reg        <= 32'sd19661;
            gh_reg         <= 16'd256;
            gv_reg         <= 16'd256;
            len_reg        <= '0;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_z_reg     <= '0;
            heading_reg    <= '0;
            pose_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_ENABLE:    enable_reg <= cfg_data[0];
                    REG_LOOKAHEAD: la_reg     <= cfg_data[30:0];
                    REG_MAX_H:     mh_reg     <= cfg_data[30:0];
                    REG_MAX_V:     mv_reg     <= cfg_data[30:0];
                    REG_YAW_RATE:  yaw_reg    <= cfg_data;
                    REG_GAIN_H:    gh_reg     <= cfg_data[15:0];
                    REG_GAIN_V:    gv_reg     <= cfg_data[15:0];
                    default:       ;
                endcase
            end
            if (in_acc)
            begin
                case (cmd)
                    CMD_CLEAR: len_reg <= '0;
                    CMD_APPEND:
                        if (mem_we)
                            len_reg <= len_reg + 1'b1;
                    CMD_POSE:
                    begin
                        pose_x_reg     <= cmd_ch.pos_x;
                        pose_y_reg     <= cmd_ch.pos_y;
                        pose_z_reg     <= cmd_ch.pos_z;
                        heading_reg    <= cmd_ch.heading;
                        pose_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (vel_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
            l2_reg <= 62'(la_reg) * 62'(la_reg);
        if (state_reg == ST_SEARCH && srch_res.done)
        begin
            dx_reg <= srch_res.dx;
            dy_reg <= srch_res.dy;
            dz_reg <= srch_res.dz;
        end
        if (state_reg == ST_GAIN)
        begin
            ax_reg <= gx[48:8];
            ay_reg <= gy[48:8];
            sx_reg <= dx_reg[DIFF_W-1];
            sy_reg <= dy_reg[DIFF_W-1];
            vz_reg <= dz_reg[DIFF_W-1] ? -$signed({1'b0, gz[48:8]}) : $signed({1'b0, gz[48:8]});
        end
        if (state_reg == ST_SQ)
        begin
            axs_reg <= ax_sh[30:0];
            ays_reg <= ay_sh[30:0];
            big_reg <= |hi_bits;
            sqx_reg <= 62'(ax_sh[30:0]) * 62'(ax_sh[30:0]);
            sqy_reg <= 62'(ay_sh[30:0]) * 62'(ay_sh[30:0]);
            mh2_reg <= 62'(mh_reg) * 62'(mh_reg);
        end
        if (state_reg == ST_CMP)
        begin
            vzc_reg <= vz_clamp;
            if (!over)
            begin
                vx_reg <= sx_reg ? -$signed({1'b0, ax_reg[30:0]}) : $signed({1'b0, ax_reg[30:0]});
                vy_reg <= sy_reg ? -$signed({1'b0, ay_reg[30:0]}) : $signed({1'b0, ay_reg[30:0]});
            end
        end
        if (state_reg == ST_SCALE && scl_done)
        begin
            vx_reg <= sx_reg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            vy_reg <= sy_reg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        end
        if (state_reg == ST_IDLE && tick_zero)
        begin
            res_f_reg <= '0;
            res_l_reg <= '0;
            res_u_reg <= '0;
        end
        if (state_reg == ST_CORDIC && rot_done)
        begin
            res_f_reg <= rot_f;
            res_l_reg <= rot_l;
            res_u_reg <= vzc_reg;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_f_reg <= res_f_reg;
            out_l_reg <= res_l_reg;
            out_u_reg <= res_u_reg;
            // the zero word of a tick without pose or path carries a zero yaw rate too
            out_y_reg <= (res_f_reg == '0 && res_l_reg == '0 && res_u_reg == '0 &&
                          !(pose_valid_reg && (len_reg != '0))) ? '0 : yaw_reg;
        end
    end

    assign vel_ch.valid       = out_valid_reg;
    assign vel_ch.vel_forward = out_f_reg;
    assign vel_ch.vel_left    = out_l_reg;
    assign vel_ch.vel_up      = out_u_reg;
    assign vel_ch.yaw_rate    = out_y_reg;

`ifndef NO_ASSERTIONS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_POINTS))
        else $error("path length beyond capacity");
    a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
        srch_res.done |-> state_reg == ST_SEARCH)
        else $error("search finished outside a tick");
    a_scale_done: assert property (@(posedge clk) disable iff (!rst_n)
        scl_done |-> state_reg == ST_SCALE)
        else $error("speed limiter finished outside its phase");
    a_silent_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && cmd == CMD_TICK && !enable_reg) |=> state_reg == ST_IDLE)
        else $error("disabled tick started work");
`endif

endmodule

>>> test/tb_scoreboard.sv
class velocity_scoreboard;
    bit [31:0] exp_fwd[$];
    bit [31:0] exp_left[$];
    bit [31:0] exp_up[$];
    bit [31:0] exp_yaw[$];
    int errors;
    int checked;

    function void note_command(bit [31:0] f, bit [31:0] l, bit [31:0] u, bit [31:0] y);
        exp_fwd.push_back(f);
        exp_left.push_back(l);
        exp_up.push_back(u);
        exp_yaw.push_back(y);
    endfunction

    function void check_command(bit [31:0] f, bit [31:0] l, bit [31:0] u, bit [31:0] y);
        bit [31:0] ef, el, eu, ey;
        if (exp_fwd.size() == 0) begin
            $error("unexpected velocity word %h %h %h %h", f, l, u, y);
            errors++;
            return;
        end
        ef = exp_fwd.pop_front();
        el = exp_left.pop_front();
        eu = exp_up.pop_front();
        ey = exp_yaw.pop_front();
        checked++;
        if (f !== ef) begin
            $error("vel_forward expected %h actual %h", ef, f);
            errors++;
        end
        if (l !== el) begin
            $error("vel_left expected %h actual %h", el, l);
            errors++;
        end
        if (u !== eu) begin
            $error("vel_up expected %h actual %h", eu, u);
            errors++;
        end
        if (y !== ey) begin
            $error("yaw_rate expected %h actual %h", ey, y);
            errors++;
        end
    endfunction

    function int pending();
        return exp_fwd.size();
    endfunction
endclass

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpf_pkg::*;

    localparam int NPTS = 256;
    localparam int STEPS = 16;
    localparam longint LIMIT = 3000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpf_in_if cmd_ch();
    lpf_out_if vel_ch();

    lookahead_path_follower_core #(.MAX_POINTS(NPTS), .CORDIC_STEPS(STEPS)) dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd_ch(cmd_ch.sink), .vel_ch(vel_ch.source)
    );

    velocity_scoreboard sb;

    // predictor state
    bit        en_r;
    longint    look_r, maxh_r, maxv_r, gainh_r, gainv_r;
    bit [31:0] yaw_r;
    longint    px[NPTS], py[NPTS], pz[NPTS];
    int        plen;
    longint    ox, oy, oz, ohead;
    bit        opose;

    longint cycles;
    int     ticks_sent, words_sent;
    bit     stall_mode;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) cycles <= cycles + 1;

    function automatic longint arith_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // squared distance of a point from the pose, 66 bits exact
    function automatic logic [67:0] range_sq(int i);
        longint d0, d1, d2;
        logic [67:0] r;
        d0 = px[i] - ox;
        d1 = py[i] - oy;
        d2 = pz[i] - oz;
        r = 68'(d0 < 0 ? -d0 : d0) * 68'(d0 < 0 ? -d0 : d0);
        r += 68'(d1 < 0 ? -d1 : d1) * 68'(d1 < 0 ? -d1 : d1);
        r += 68'(d2 < 0 ? -d2 : d2) * 68'(d2 < 0 ? -d2 : d2);
        return r;
    endfunction

    function automatic longint gain_mul(longint e, longint g);
        longint m;
        m = ((e < 0 ? -e : e) * g) >>> 8;
        return e < 0 ? -m : m;
    endfunction

    function automatic longint root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
            begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void set_reg(reg_idx_t idx, logic [31:0] v);
        case (idx)
            REG_ENABLE:    en_r = v[0];
            REG_LOOKAHEAD: look_r = longint'(v[30:0]);
            REG_MAX_H:     maxh_r = longint'(v[30:0]);
            REG_MAX_V:     maxv_r = longint'(v[30:0]);
            REG_YAW_RATE:  yaw_r = v;
            REG_GAIN_H:    gainh_r = longint'(v[15:0]);
            REG_GAIN_V:    gainv_r = longint'(v[15:0]);
            default: ;
        endcase
    endfunction

    // apply one accepted word and record the command it yields
    function automatic void follow_word(cmd_t c, logic signed [31:0] x, logic signed [31:0] y,
                                        logic signed [31:0] z, logic signed [15:0] h);
        int near, tgt;
        logic [67:0] best, dd, l2;
        longint vx, vy, vz, ax, ay, sp, th, cx, cy, dx, dy, kq;
        int s;
        case (c)
            CMD_CLEAR: plen = 0;
            CMD_APPEND:
                if (plen < NPTS)
                begin
                    px[plen] = x;
                    py[plen] = y;
                    pz[plen] = z;
                    plen++;
                end
            CMD_POSE:
            begin
                ox = x;
                oy = y;
                oz = z;
                ohead = h;
                opose = 1;
            end
            default:
            begin
                if (!en_r) return;
                if (!opose || plen == 0)
                begin
                    sb.note_command(0, 0, 0, 0);
                    return;
                end
                near = 0;
                best = range_sq(0);
                for (int i = 1; i < plen; i++)
                begin
                    dd = range_sq(i);
                    if (dd < best)
                    begin
                        best = dd;
                        near = i;
                    end
                end
                l2 = 68'(look_r) * 68'(look_r);
                tgt = plen - 1;
                for (int i = near; i < plen; i++)
                begin
                    tgt = i;
                    if (!(range_sq(i) < l2)) break;
                end
                vx = gain_mul(px[tgt] - ox, gainh_r);
                vy = gain_mul(py[tgt] - oy, gainh_r);
                vz = gain_mul(pz[tgt] - oz, gainv_r);
                ax = vx < 0 ? -vx : vx;
                ay = vy < 0 ? -vy : vy;
                if (ax >= 64'sd2147483648 || ay >= 64'sd2147483648 ||
                    65'(ax * ax) + 65'(ay * ay) > 65'(maxh_r * maxh_r))
                begin
                    s = 0;
                    while ((ax >>> s) >= 64'sd2147483648 || (ay >>> s) >= 64'sd2147483648)
                        s++;
                    ax >>>= s;
                    ay >>>= s;
                    sp = root_floor(64'(ax) * 64'(ax) + 64'(ay) * 64'(ay));
                    if (sp == 0)
                    begin
                        ax = 0;
                        ay = 0;
                    end
                    else
                    begin
                        ax = longint'((64'(ax) * 64'(maxh_r)) / 64'(sp));
                        ay = longint'((64'(ay) * 64'(maxh_r)) / 64'(sp));
                    end
                    vx = vx < 0 ? -ax : ax;
                    vy = vy < 0 ? -ay : ay;
                end
                if (vz > maxv_r) vz = maxv_r;
                if (vz < -maxv_r) vz = -maxv_r;
                th = -ohead * 65536;
                cx = vx;
                cy = vy;
                if (th > 64'sd1073741824)
                begin
                    cx = -cx;
                    cy = -cy;
                    th -= 64'sd2147483648;
                end
                else if (th < -64'sd1073741824)
                begin
                    cx = -cx;
                    cy = -cy;
                    th += 64'sd2147483648;
                end
                for (int k = 0; k < STEPS && k < 24; k++)
                begin
                    dx = arith_shr(cy, k);
                    dy = arith_shr(cx, k);
                    if (th >= 0)
                    begin
                        cx -= dx;
                        cy += dy;
                        th -= longint'(atan_at(5'(k)));
                    end
                    else
                    begin
                        cx += dx;
                        cy -= dy;
                        th += longint'(atan_at(5'(k)));
                    end
                end
                kq = KINF_Q30;
                if (2 * STEPS < 63) kq += (KINF_Q30 * 2 / 3) >> (2 * STEPS);
                cx = sat32(arith_shr(cx * kq, 30));
                cy = sat32(arith_shr(cy * kq, 30));
                sb.note_command(cx[31:0], cy[31:0], vz[31:0], yaw_r);
            end
        endcase
    endfunction

    // watch the input handshake and feed the predictor
    always @(posedge clk)
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            follow_word(cmd_t'(cmd_ch.command), cmd_ch.pos_x, cmd_ch.pos_y, cmd_ch.pos_z,
                        cmd_ch.heading);

    always @(posedge clk)
        if (rst_n && vel_ch.valid && vel_ch.ready)
            sb.check_command(vel_ch.vel_forward, vel_ch.vel_left, vel_ch.vel_up,
                             vel_ch.yaw_rate);

    // receiver stall pattern: runs of free flow and runs of random stalls
    int stall_run;
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 2) == 0;
            stall_run <= $urandom_range(1, 40);
        end
        else
        begin
            stall_run <= stall_run - 1;
        end
        vel_ch.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge clk)
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end

    int burst_left;

    task automatic send_word(cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [15:0] h);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= c;
        cmd_ch.pos_x <= x;
        cmd_ch.pos_y <= y;
        cmd_ch.pos_z <= z;
        cmd_ch.heading <= h;
        do @(posedge clk); while (!cmd_ch.ready);
        words_sent++;
        if (c == CMD_TICK) ticks_sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        set_reg(idx, v);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 20 * 65536) - 10 * 65536;
            default: return $urandom_range(0, 400 * 65536) - 200 * 65536;
        endcase
    endfunction

    task automatic send_path(int n, int kind);
        send_word(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < n; i++)
            send_word(CMD_APPEND, rand_coord(kind), rand_coord(kind), rand_coord(kind),
                      $urandom);
    endtask

    task automatic random_phase(int words);
        int kind;
        int r;
        kind = $urandom_range(0, 2);
        send_path($urandom_range(1, 12), kind);
        for (int i = 0; i < words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                send_word(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
            else if (r < 80)
                send_word(CMD_POSE, rand_coord(kind), rand_coord(kind), rand_coord(kind),
                          $urandom);
            else if (r < 95)
                send_word(CMD_APPEND, rand_coord(kind), rand_coord(kind), rand_coord(kind),
                          $urandom);
            else
                send_path($urandom_range(0, 6), kind);
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        en_r = 1;
        look_r = 65536;
        maxh_r = 65536;
        maxv_r = 32768;
        yaw_r = 19661;
        gainh_r = 256;
        gainv_r = 256;
        plen = 0;
        opose = 0;
        ox = 0;
        oy = 0;
        oz = 0;
        ohead = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_ENABLE;
        cfg_data = 0;
        cmd_ch.valid = 0;
        cmd_ch.command = CMD_CLEAR;
        cmd_ch.pos_x = 0;
        cmd_ch.pos_y = 0;
        cmd_ch.pos_z = 0;
        cmd_ch.heading = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // no pose and empty path both give zeros; then ticks on extreme and short paths
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_APPEND, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_POSE, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_TICK, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
        send_word(CMD_APPEND, 0, 0, 0, 0);
        send_word(CMD_APPEND, 65536, 0, 65536, 0);
        send_word(CMD_APPEND, 65536, 65536, -65536, 0);
        send_word(CMD_POSE, 0, 0, 0, 16'h8000);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_POSE, 100, -100, 0, 16'h4000);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_POSE, 0, 0, 0, 16'hC001);
        send_word(CMD_TICK, 0, 0, 0, 0);
        drain();

        // fill the path to overflow, then tick
        write_reg(REG_GAIN_H, 16'hFFFF);
        write_reg(REG_GAIN_V, 16'hFFFF);
        write_reg(REG_MAX_H, 32'h7FFFFFFF);
        write_reg(REG_MAX_V, 32'h7FFFFFFF);
        write_reg(REG_LOOKAHEAD, 32'h7FFFFFFF);
        write_reg(REG_YAW_RATE, 32'h80000000);
        send_path(NPTS + 2, 0);
        send_word(CMD_TICK, 0, 0, 0, 0);
        send_word(CMD_POSE, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
        send_word(CMD_TICK, 0, 0, 0, 0);
        drain();

        write_reg(REG_ENABLE, 0);
        send_word(CMD_TICK, 0, 0, 0, 0);
        drain();
        write_reg(REG_ENABLE, 1);
        write_reg(REG_LOOKAHEAD, 0);
        write_reg(REG_MAX_H, 0);
        write_reg(REG_MAX_V, 0);
        write_reg(REG_GAIN_H, 0);
        write_reg(REG_GAIN_V, 0);
        write_reg(REG_YAW_RATE, 32'h7FFFFFFF);
        random_phase(20);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_LOOKAHEAD, $urandom_range(0, 8 * 65536));
            write_reg(REG_MAX_H, ph[0] ? $urandom_range(0, 4 * 65536) : {1'b0, 31'($urandom)});
            write_reg(REG_MAX_V, ph[1] ? $urandom_range(0, 2 * 65536) : {1'b0, 31'($urandom)});
            write_reg(REG_GAIN_H, $urandom_range(0, 65535));
            write_reg(REG_GAIN_V, $urandom_range(0, 65535));
            write_reg(REG_YAW_RATE, $urandom);
            write_reg(REG_ENABLE, ph != 5);
            random_phase(25);
        end

        $display("%0d words sent, %0d ticks, %0d velocity words checked",
                 words_sent, ticks_sent, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
